### src/wtr_pkg.sv
package wtr_pkg;

  // result width per colour channel
  localparam int COLOUR_BITS = 12;
  localparam int WAVE_BITS   = 14;
  localparam int FRAC_BITS   = 16;
  localparam int DIFF_BITS   = 11;
  localparam int SPAN_BITS   = 11;
  localparam int RECIP_SHIFT = 11;
  localparam int RECIP_BITS  = 20;
  localparam int COEF_BITS   = 19;
  localparam int PROD_BITS   = 36;
  localparam int SUM_BITS    = 38;
  localparam int NSTAGE      = 7;
  localparam int NBANDS      = 10;
  localparam int BIDX_BITS   = 4;

  localparam longint RECIP_NUM = 64'd1 << (FRAC_BITS + RECIP_SHIFT);

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_t;

  typedef logic [BIDX_BITS-1:0] bidx_t;

  typedef struct packed {
    chan_t                        chan;
    logic [WAVE_BITS-1:0]         lo;
    logic [WAVE_BITS-1:0]         hi;
    logic [SPAN_BITS-1:0]         span;
    logic [RECIP_BITS-1:0]        recip;
    logic signed [COEF_BITS-1:0]  c0;
    logic signed [COEF_BITS-1:0]  c1;
    logic signed [COEF_BITS-1:0]  c2;
  } band_t;

  // per-stage load enables from the pipeline control
  typedef struct packed {
    logic [NSTAGE-1:0] en;
  } pipe_ctl_t;

  // band table in priority order within each channel, limits in 1/16 nm,
  // recip = floor(2^27 / span), coefficients in signed q.16
  localparam band_t BANDS [NBANDS] = '{
    '{CH_RED,   14'd6400,  14'd6560,  11'd160,  20'(RECIP_NUM / 160),
      19'sd0,     19'sd21627,  -19'sd13107},
    '{CH_RED,   14'd6560,  14'd7600,  11'd1040, 20'(RECIP_NUM / 1040),
      19'sd9175,  19'sd0,      -19'sd8520},
    '{CH_RED,   14'd8720,  14'd9520,  11'd800,  20'(RECIP_NUM / 800),
      19'sd0,     19'sd129761, -19'sd65536},
    '{CH_RED,   14'd9520,  14'd10400, 11'd880,  20'(RECIP_NUM / 880),
      19'sd64225, 19'sd3932,   -19'sd26214},
    '{CH_RED,   14'd10400, 14'd11200, 11'd800,  20'(RECIP_NUM / 800),
      19'sd42598, -19'sd55050, 19'sd13107},
    '{CH_GREEN, 14'd6640,  14'd7600,  11'd960,  20'(RECIP_NUM / 960),
      19'sd0,     19'sd0,      19'sd52429},
    '{CH_GREEN, 14'd7600,  14'd9440,  11'd1840, 20'(RECIP_NUM / 1840),
      19'sd52429, 19'sd49807,  -19'sd52429},
    '{CH_GREEN, 14'd9360,  14'd10224, 11'd864,  20'(RECIP_NUM / 864),
      19'sd55050, -19'sd55050, 19'sd0},
    '{CH_BLUE,  14'd6400,  14'd7600,  11'd1200, 20'(RECIP_NUM / 1200),
      19'sd0,     19'sd144179, -19'sd98304},
    '{CH_BLUE,  14'd7600,  14'd8960,  11'd1360, 20'(RECIP_NUM / 1360),
      19'sd45875, -19'sd65536, 19'sd19661}
  };

endpackage

### src/wtr_pipe_ctrl.sv
module wtr_pipe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output wtr_pkg::pipe_ctl_t  ctl
);

  logic [wtr_pkg::NSTAGE-1:0] valid_r;
  logic [wtr_pkg::NSTAGE-1:0] valid_nxt;
  logic [wtr_pkg::NSTAGE:0]   free;

  // a stage may load when empty or when the stage after it moves on
  always_comb begin
    free[wtr_pkg::NSTAGE] = out_tready;
    for (int i = wtr_pkg::NSTAGE - 1; i >= 0; i--) begin
      free[i] = !valid_r[i] || free[i+1];
    end
  end

  // valid bits follow the data, bubbles are squeezed out
  always_comb begin
    if (free[0]) begin
      valid_nxt[0] = in_tvalid;
    end else begin
      valid_nxt[0] = valid_r[0];
    end
    for (int i = 1; i < wtr_pkg::NSTAGE; i++) begin
      if (free[i]) begin
        valid_nxt[i] = valid_r[i-1];
      end else begin
        valid_nxt[i] = valid_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign ctl.en     = free[wtr_pkg::NSTAGE-1:0];
  assign in_tready  = free[0];
  assign out_tvalid = valid_r[wtr_pkg::NSTAGE-1];

endmodule

### src/wtr_lane.sv
module wtr_lane (
  input  logic                                clk,
  input  wtr_pkg::chan_t                      chan,
  input  wtr_pkg::pipe_ctl_t                  ctl,
  input  logic [wtr_pkg::WAVE_BITS-1:0]       wavelength,
  output logic [wtr_pkg::COLOUR_BITS-1:0]     level
);

  localparam int XBITS = wtr_pkg::DIFF_BITS + wtr_pkg::FRAC_BITS;
  localparam int MBITS = wtr_pkg::DIFF_BITS + wtr_pkg::RECIP_BITS;
  localparam int RBITS = wtr_pkg::SPAN_BITS + 1;

  // stage 0: band decode
  logic                               hit0_r, hit0_nxt;
  wtr_pkg::bidx_t                     bidx0_r, bidx0_nxt;
  logic [wtr_pkg::DIFF_BITS-1:0]      d0_r, d0_nxt;
  // stage 1: quotient estimate
  logic                               hit1_r;
  wtr_pkg::bidx_t                     bidx1_r;
  logic [wtr_pkg::DIFF_BITS-1:0]      d1_r;
  logic [wtr_pkg::FRAC_BITS-1:0]      q1_r;
  logic [MBITS-1:0]                   qprod;
  // stage 2: back-multiply
  logic                               hit2_r;
  wtr_pkg::bidx_t                     bidx2_r;
  logic [wtr_pkg::DIFF_BITS-1:0]      d2_r;
  logic [wtr_pkg::FRAC_BITS-1:0]      q2_r;
  logic [XBITS-1:0]                   bp2_r;
  // stage 3: corrected position t
  logic                               hit3_r;
  wtr_pkg::bidx_t                     bidx3_r;
  logic [wtr_pkg::FRAC_BITS-1:0]      t3_r;
  logic [XBITS-1:0]                   rem;
  logic                               bump;
  // stage 4: square
  logic                               hit4_r;
  wtr_pkg::bidx_t                     bidx4_r;
  logic [wtr_pkg::FRAC_BITS-1:0]      t4_r;
  logic [wtr_pkg::FRAC_BITS-1:0]      sq4_r;
  logic [2*wtr_pkg::FRAC_BITS-1:0]    sq_full;
  // stage 5: coefficient products
  logic                               hit5_r;
  wtr_pkg::bidx_t                     bidx5_r;
  logic signed [wtr_pkg::PROD_BITS-1:0] a5_r, a5_nxt;
  logic signed [wtr_pkg::PROD_BITS-1:0] b5_r, b5_nxt;
  // stage 6: sum and clamp
  logic signed [wtr_pkg::SUM_BITS-1:0]  vsum;
  logic [wtr_pkg::COLOUR_BITS-1:0]      level_r, level_nxt;

  // first matching band of this channel wins
  always_comb begin
    logic found;
    logic [wtr_pkg::WAVE_BITS-1:0] diff;
    found     = 1'b0;
    bidx0_nxt = '0;
    diff      = '0;
    for (int i = 0; i < wtr_pkg::NBANDS; i++) begin
      if (!found && wtr_pkg::BANDS[i].chan == chan &&
          wavelength >= wtr_pkg::BANDS[i].lo && wavelength < wtr_pkg::BANDS[i].hi) begin
        found     = 1'b1;
        bidx0_nxt = wtr_pkg::BIDX_BITS'(i);
        diff      = wavelength - wtr_pkg::BANDS[i].lo;
      end
    end
    hit0_nxt = found;
    d0_nxt   = diff[wtr_pkg::DIFF_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      hit0_r  <= hit0_nxt;
      bidx0_r <= bidx0_nxt;
      d0_r    <= d0_nxt;
    end
  end

  // reciprocal multiply, estimate is exact or one low
  assign qprod = MBITS'(d0_r) * MBITS'(wtr_pkg::BANDS[bidx0_r].recip);

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      hit1_r  <= hit0_r;
      bidx1_r <= bidx0_r;
      d1_r    <= d0_r;
      q1_r    <= qprod[wtr_pkg::RECIP_SHIFT +: wtr_pkg::FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      hit2_r  <= hit1_r;
      bidx2_r <= bidx1_r;
      d2_r    <= d1_r;
      q2_r    <= q1_r;
      bp2_r   <= XBITS'(q1_r) * XBITS'(wtr_pkg::BANDS[bidx1_r].span);
    end
  end

  // remainder stays below twice the span, one correction step
  assign rem  = {d2_r, {wtr_pkg::FRAC_BITS{1'b0}}} - bp2_r;
  assign bump = rem[RBITS-1:0] >= RBITS'(wtr_pkg::BANDS[bidx2_r].span);

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      hit3_r  <= hit2_r;
      bidx3_r <= bidx2_r;
      t3_r    <= q2_r + wtr_pkg::FRAC_BITS'(bump);
    end
  end

  assign sq_full = (2*wtr_pkg::FRAC_BITS)'(t3_r) * (2*wtr_pkg::FRAC_BITS)'(t3_r);

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      hit4_r  <= hit3_r;
      bidx4_r <= bidx3_r;
      t4_r    <= t3_r;
      sq4_r   <= sq_full[2*wtr_pkg::FRAC_BITS-1:wtr_pkg::FRAC_BITS];
    end
  end

  // linear and square terms in parallel
  always_comb begin
    logic signed [wtr_pkg::FRAC_BITS:0] ts;
    logic signed [wtr_pkg::FRAC_BITS:0] ss;
    ts     = {1'b0, t4_r};
    ss     = {1'b0, sq4_r};
    a5_nxt = wtr_pkg::PROD_BITS'(wtr_pkg::BANDS[bidx4_r].c1) * wtr_pkg::PROD_BITS'(ts);
    b5_nxt = wtr_pkg::PROD_BITS'(wtr_pkg::BANDS[bidx4_r].c2) * wtr_pkg::PROD_BITS'(ss);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      hit5_r  <= hit4_r;
      bidx5_r <= bidx4_r;
      a5_r    <= a5_nxt;
      b5_r    <= b5_nxt;
    end
  end

  // q.32 sum, truncate to the colour width, clamp both ends
  assign vsum = (wtr_pkg::SUM_BITS'(wtr_pkg::BANDS[bidx5_r].c0) <<< wtr_pkg::FRAC_BITS)
              + wtr_pkg::SUM_BITS'(a5_r) + wtr_pkg::SUM_BITS'(b5_r);

  always_comb begin
    if (!hit5_r || vsum[wtr_pkg::SUM_BITS-1]) begin
      level_nxt = '0;
    end else if (|vsum[wtr_pkg::SUM_BITS-2:2*wtr_pkg::FRAC_BITS]) begin
      level_nxt = '1;
    end else begin
      level_nxt = vsum[2*wtr_pkg::FRAC_BITS-1 -: wtr_pkg::COLOUR_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[6]) begin
      level_r <= level_nxt;
    end
  end

  assign level = level_r;

endmodule

### src/wavelength_to_rgb.sv
// wavelength to rgb colour, three channel lanes side by side
// pipeline: one register stage each for decode, reciprocal, back-multiply, correction,
// square, coefficient products and sum, from input request to result
// throughput: one request per cycle while the output is not stalled, every stage is fully pipelined
// a stalled output holds the pipeline, empty stages still fill behind it
// reset (synchronous, active low) clears all stage valid bits; no other state
module wavelength_to_rgb (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [13:0] wavelength, [15:14] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [11:0] red, [23:12] green, [35:24] blue, [39:36] zero
);

  wtr_pkg::pipe_ctl_t                  ctl;
  logic [wtr_pkg::WAVE_BITS-1:0]       wave;
  logic [wtr_pkg::COLOUR_BITS-1:0]     red;
  logic [wtr_pkg::COLOUR_BITS-1:0]     green;
  logic [wtr_pkg::COLOUR_BITS-1:0]     blue;

  assign wave = in_tdata[wtr_pkg::WAVE_BITS-1:0];

  // stage valid tracking and stall control
  wtr_pipe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl)
  );

  // one lane per colour
  wtr_lane u_red (
    .clk        (clk),
    .chan       (wtr_pkg::CH_RED),
    .ctl        (ctl),
    .wavelength (wave),
    .level      (red)
  );

  wtr_lane u_green (
    .clk        (clk),
    .chan       (wtr_pkg::CH_GREEN),
    .ctl        (ctl),
    .wavelength (wave),
    .level      (green)
  );

  wtr_lane u_blue (
    .clk        (clk),
    .chan       (wtr_pkg::CH_BLUE),
    .ctl        (ctl),
    .wavelength (wave),
    .level      (blue)
  );

  assign out_tdata = {4'b0000, blue, green, red};

endmodule
